FILE: design/pds_pkg.sv
// Shared types, constants and helpers of the polynomial dominance select unit.
package pds_pkg;

   localparam int unsigned COEFF_W = 48;
   localparam int unsigned IDX_W = 4;
   localparam int unsigned EMIT_MAX = 16;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic select_max;
      logic [IDX_W-1:0] index;
      logic [COEFF_W-1:0] first_coeff;
      logic [COEFF_W-1:0] second_coeff;
      logic first_approx;
      logic second_approx;
      logic last;
   } pds_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_index;
      logic [COEFF_W-1:0] out_coeff;
      logic used_first;
      logic used_second;
      logic approximated;
      logic out_last;
   } pds_rsp_type;

   // A request after classification, as it waits in the queue.
   typedef struct packed {
      logic store_en;
      logic [IDX_W-1:0] index;
      logic [COEFF_W-1:0] first_coeff;
      logic [COEFF_W-1:0] second_coeff;
      logic select_max;
      logic first_approx;
      logic second_approx;
      logic last;
   } pds_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SAMPLE,
      ST_EMIT
   } pds_state_type;

   typedef enum logic [1:0] {
      CH_NONE,
      CH_FIRST,
      CH_SECOND
   } pds_choice_type;

   function automatic pds_choice_type pds_decide(input logic ge, input logic le,
                                                 input logic select_max);
      pds_choice_type ch;
      ch = CH_NONE;
      if ((ge && select_max) || (le && !select_max)) begin
         ch = CH_FIRST;
      end else if ((le && select_max) || (ge && !select_max)) begin
         ch = CH_SECOND;
      end
      return ch;
   endfunction

endpackage

FILE: design/pds_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module pds_front #(
   parameter int unsigned NUM_COEFFS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  pds_pkg::pds_req_type req_item,
   output logic cmd_valid,
   output pds_pkg::pds_cmd_type cmd,
   input  logic cmd_pop
);
   import pds_pkg::*;

   pds_cmd_type q_ff [2];
   logic wp_ff, wp_in;
   logic rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   pds_cmd_type push_cmd;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rp_ff];

   always_comb begin
      push_cmd.store_en = (32'(req_item.index) < 32'(NUM_COEFFS));
      push_cmd.index = req_item.index;
      push_cmd.first_coeff = req_item.first_coeff;
      push_cmd.second_coeff = req_item.second_coeff;
      push_cmd.select_max = req_item.select_max;
      push_cmd.first_approx = req_item.first_approx;
      push_cmd.second_approx = req_item.second_approx;
      push_cmd.last = req_item.last;
   end

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = (cmd_pop && cmd_valid) ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/pds_back.sv
// Back end: stores coefficients, compares, samples, emits chosen or merged result.
module pds_back #(
   parameter int unsigned NUM_COEFFS = 16,
   parameter int unsigned SAMPLES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  pds_pkg::pds_cmd_type cmd,
   output logic cmd_pop,
   output logic rsp_strobe,
   output pds_pkg::pds_rsp_type rsp_item
);
   import pds_pkg::*;

   localparam int unsigned AW = $clog2(NUM_COEFFS);
   localparam int unsigned CW = $clog2(NUM_COEFFS + 1);
   localparam int unsigned KW = $clog2(SAMPLES + 1);
   localparam int unsigned RW = $clog2(SAMPLES) + 1;
   localparam int unsigned EMIT_N = (NUM_COEFFS < EMIT_MAX) ? NUM_COEFFS : EMIT_MAX;
   localparam int unsigned PSTEP = 65536 / SAMPLES;
   localparam int unsigned PREM = 65536 % SAMPLES;

   pds_state_type state_ff, state_in;
   pds_choice_type choice_ff, choice_in;

   logic [COEFF_W-1:0] mem_a_ff [NUM_COEFFS];
   logic [COEFF_W-1:0] mem_b_ff [NUM_COEFFS];
   logic [COEFF_W-1:0] rd_a_ff, rd_b_ff;
   logic hi_ff;
   logic [COEFF_W-1:0] rd_a, rd_b;

   logic [CW-1:0] iss_ff, iss_in;
   logic [CW-1:0] limit;
   logic issue_go;
   logic s1_v_ff;
   logic [CW-1:0] s1_idx_ff;
   logic s2_v_ff;
   logic round_done;

   logic ge_ff, ge_in, le_ff, le_in;
   logic select_max_ff, fa_ff, sa_ff;

   logic [KW-1:0] k_ff;
   logic [16:0] q_ff;
   logic [RW-1:0] r_ff;
   logic [RW-1:0] r_sum;
   logic [16:0] pw_ff;
   logic [48:0] term_a_ff, term_b_ff;
   logic [15:0] acc_a_ff, acc_b_ff;
   logic sat_a_ff, sat_b_ff;
   logic [49:0] sum_a, sum_b;
   logic [16:0] val_a, val_b;
   logic [64:0] prod_a, prod_b;
   logic [33:0] prod_p;

   logic rsp_strobe_ff;
   pds_rsp_type rsp_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   // Entries above the loadable powers read as zero.
   assign rd_a = hi_ff ? '0 : rd_a_ff;
   assign rd_b = hi_ff ? '0 : rd_b_ff;

   // Output decode of the sequencer.
   always_comb begin
      cmd_pop = 1'b0;
      limit = CW'(NUM_COEFFS);
      unique case (state_ff)
         ST_IDLE: cmd_pop = cmd_valid;
         ST_COMPARE: limit = CW'(NUM_COEFFS);
         ST_SAMPLE: limit = CW'(NUM_COEFFS);
         ST_EMIT: limit = CW'(EMIT_N);
         default: limit = CW'(NUM_COEFFS);
      endcase
      issue_go = (state_ff != ST_IDLE) && (iss_ff < limit);
      round_done = (state_ff != ST_IDLE) && (iss_ff == limit) && !s1_v_ff && !s2_v_ff;
   end

   always_comb begin
      sum_a = {1'b0, term_a_ff} + 50'(acc_a_ff);
      sum_b = {1'b0, term_b_ff} + 50'(acc_b_ff);
      val_a = sat_a_ff ? ONE_Q16 : {1'b0, acc_a_ff};
      val_b = sat_b_ff ? ONE_Q16 : {1'b0, acc_b_ff};
      prod_a = 65'(rd_a) * 65'(pw_ff);
      prod_b = 65'(rd_b) * 65'(pw_ff);
      prod_p = 34'(pw_ff) * 34'(q_ff);
      r_sum = r_ff + RW'(PREM);
   end

   // Dominance flags and choice.
   always_comb begin
      ge_in = ge_ff;
      le_in = le_ff;
      choice_in = choice_ff;
      if (state_ff == ST_IDLE && cmd_valid && cmd.last) begin
         ge_in = 1'b1;
         le_in = 1'b1;
      end else if (state_ff == ST_COMPARE) begin
         if (s1_v_ff) begin
            ge_in = ge_ff && !(rd_a < rd_b);
            le_in = le_ff && !(rd_a > rd_b);
         end
         if (round_done) begin
            choice_in = pds_decide(ge_ff, le_ff, select_max_ff);
            if (pds_decide(ge_ff, le_ff, select_max_ff) == CH_NONE) begin
               ge_in = 1'b1;
               le_in = 1'b1;
            end
         end
      end else if (state_ff == ST_SAMPLE && round_done) begin
         ge_in = ge_ff && !(val_a < val_b);
         le_in = le_ff && !(val_a > val_b);
         choice_in = pds_decide(ge_in, le_in, select_max_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid && cmd.last) state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (round_done) begin
               state_in = (pds_decide(ge_ff, le_ff, select_max_ff) == CH_NONE) ?
                          ST_SAMPLE : ST_EMIT;
            end
         end
         ST_SAMPLE: if (round_done && k_ff == KW'(SAMPLES)) state_in = ST_EMIT;
         ST_EMIT: if (round_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      iss_in = iss_ff;
      if (issue_go) begin
         iss_in = iss_ff + CW'(1);
      end else if (round_done || state_ff == ST_IDLE) begin
         iss_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         choice_ff <= CH_NONE;
         iss_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         ge_ff <= 1'b1;
         le_ff <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         choice_ff <= choice_in;
         iss_ff <= iss_in;
         s1_v_ff <= issue_go;
         s2_v_ff <= s1_v_ff && (state_ff == ST_SAMPLE);
         ge_ff <= ge_in;
         le_ff <= le_in;
         rsp_strobe_ff <= s1_v_ff && (state_ff == ST_EMIT);
      end
   end

   // Coefficient stores.
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.store_en) begin
         mem_a_ff[AW'(cmd.index)] <= cmd.first_coeff;
         mem_b_ff[AW'(cmd.index)] <= cmd.second_coeff;
      end
      rd_a_ff <= mem_a_ff[iss_ff[AW-1:0]];
      rd_b_ff <= mem_b_ff[iss_ff[AW-1:0]];
      hi_ff <= (32'(iss_ff) >= 32'(EMIT_MAX));
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      s1_idx_ff <= iss_ff;
      if (cmd_pop && cmd.last) begin
         select_max_ff <= cmd.select_max;
         fa_ff <= cmd.first_approx;
         sa_ff <= cmd.second_approx;
      end
      if (state_ff == ST_COMPARE && round_done) begin
         k_ff <= '0;
         q_ff <= '0;
         r_ff <= '0;
         pw_ff <= ONE_Q16;
         acc_a_ff <= '0;
         acc_b_ff <= '0;
         sat_a_ff <= 1'b0;
         sat_b_ff <= 1'b0;
      end else if (state_ff == ST_SAMPLE) begin
         if (round_done) begin
            // Next sample point, p = floor(k * 65536 / SAMPLES) kept incrementally.
            k_ff <= k_ff + KW'(1);
            if (r_sum >= RW'(SAMPLES)) begin
               r_ff <= r_sum - RW'(SAMPLES);
               q_ff <= q_ff + 17'(PSTEP) + 17'd1;
            end else begin
               r_ff <= r_sum;
               q_ff <= q_ff + 17'(PSTEP);
            end
            pw_ff <= ONE_Q16;
            acc_a_ff <= '0;
            acc_b_ff <= '0;
            sat_a_ff <= 1'b0;
            sat_b_ff <= 1'b0;
         end else begin
            if (s1_v_ff) begin
               term_a_ff <= prod_a[64:16];
               term_b_ff <= prod_b[64:16];
               pw_ff <= prod_p[32:16];
            end
            if (s2_v_ff) begin
               if (!sat_a_ff) begin
                  if (sum_a >= 50'(ONE_Q16)) sat_a_ff <= 1'b1;
                  else acc_a_ff <= sum_a[15:0];
               end
               if (!sat_b_ff) begin
                  if (sum_b >= 50'(ONE_Q16)) sat_b_ff <= 1'b1;
                  else acc_b_ff <= sum_b[15:0];
               end
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      rsp_ff.out_index <= IDX_W'(s1_idx_ff);
      rsp_ff.out_last <= (s1_idx_ff == CW'(EMIT_N - 1));
      rsp_ff.used_first <= (choice_ff != CH_SECOND);
      rsp_ff.used_second <= (choice_ff != CH_FIRST);
      unique case (choice_ff)
         CH_FIRST: begin
            rsp_ff.out_coeff <= rd_a;
            rsp_ff.approximated <= fa_ff;
         end
         CH_SECOND: begin
            rsp_ff.out_coeff <= rd_b;
            rsp_ff.approximated <= sa_ff;
         end
         default: begin
            rsp_ff.out_coeff <= (rd_a > rd_b) ? rd_a : rd_b;
            rsp_ff.approximated <= 1'b1;
         end
      endcase
   end

endmodule

FILE: design/polynomial_dominance_select_unit.sv
// Top level of the polynomial dominance select unit.
//
//   channel   ports                        handshake
//   request   start, busy, req_item        taken when start is high and busy is low
//   result    rsp_strobe, rsp_item         each result shown for a single cycle, cannot be held off
//
// A request without last passes the two-entry queue and is stored once the idle back end pops it.
// A last request runs the coefficient compare; if that is mixed,
// the shared multiply pipeline samples SAMPLES+1 points.
// The results then follow on consecutive cycles, min(NUM_COEFFS,16) of them.
// Reset is synchronous; the stores hold no reset value and must be loaded before use.
// busy is high only while the queue is full behind a running comparison, sampling or result burst.
module polynomial_dominance_select_unit #(
   parameter int unsigned NUM_COEFFS = 16,
   parameter int unsigned SAMPLES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  pds_pkg::pds_req_type req_item,
   output logic rsp_strobe,
   output pds_pkg::pds_rsp_type rsp_item
);
   import pds_pkg::*;

   logic cmd_valid;
   logic cmd_pop;
   pds_cmd_type cmd;

   pds_front #(
      .NUM_COEFFS(NUM_COEFFS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   pds_back #(
      .NUM_COEFFS(NUM_COEFFS),
      .SAMPLES(SAMPLES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

`ifndef NO_ASSERTIONS
   // A result burst ends before the next comparison can start emitting.
   a_burst_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.out_last |=> !rsp_strobe)
      else $error("result directly after final result");

   // Within a burst the powers follow one another on consecutive cycles.
   a_burst_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.out_last |=>
         rsp_strobe && (rsp_item.out_index == 4'($past(rsp_item.out_index) + 4'd1)))
      else $error("result burst broken");

   // Every result draws on at least one polynomial.
   a_used: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.used_first || rsp_item.used_second)
      else $error("result uses neither polynomial");
`endif

endmodule

FILE: sim/tb_top.sv
// Testbench for the polynomial dominance select unit: directed and random requests checked against a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pds_pkg::*;

   localparam int unsigned NCOEF = 16;
   localparam int unsigned NSAMP = 64;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   pds_req_type req_item;
   logic rsp_strobe;
   pds_rsp_type rsp_item;

   int unsigned error_count;
   longint unsigned cycle_count;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   class selection_scoreboard;
      logic [COEFF_W-1:0] first_coeffs[NCOEF];
      logic [COEFF_W-1:0] second_coeffs[NCOEF];
      pds_rsp_type pending_rsp[$];

      function automatic logic [16:0] clamped_value(input logic [COEFF_W-1:0] c[NCOEF],
                                                   input logic [16:0] p);
         logic [63:0] acc;
         logic [63:0] pw;
         logic [63:0] term;
         acc = 0;
         pw = 64'h10000;
         for (int i = 0; i < NCOEF; i++) begin
            term = (64'(c[i]) * pw) >> 16;
            if (term >= 64'h10000 - acc) return ONE_Q16;
            acc += term;
            pw = (pw * 64'(p)) >> 16;
         end
         return acc[16:0];
      endfunction

      function automatic pds_choice_type pick(input logic ge, input logic le, input logic wm);
         if ((ge && wm) || (le && !wm)) return CH_FIRST;
         if ((le && wm) || (ge && !wm)) return CH_SECOND;
         return CH_NONE;
      endfunction

      function automatic void note_request(input pds_req_type r);
         logic ge;
         logic le;
         logic [16:0] p;
         logic [16:0] f1;
         logic [16:0] f2;
         pds_choice_type ch;
         pds_rsp_type o;
         first_coeffs[r.index] = r.first_coeff;
         second_coeffs[r.index] = r.second_coeff;
         if (!r.last) return;
         ge = 1;
         le = 1;
         for (int i = 0; i < NCOEF; i++) begin
            if (first_coeffs[i] < second_coeffs[i]) ge = 0;
            if (first_coeffs[i] > second_coeffs[i]) le = 0;
         end
         ch = pick(ge, le, r.select_max);
         if (ch == CH_NONE) begin
            ge = 1;
            le = 1;
            for (int k = 0; k <= NSAMP; k++) begin
               p = 17'((k * 65536) / NSAMP);
               f1 = clamped_value(first_coeffs, p);
               f2 = clamped_value(second_coeffs, p);
               if (f1 < f2) ge = 0;
               if (f1 > f2) le = 0;
            end
            ch = pick(ge, le, r.select_max);
         end
         for (int i = 0; i < NCOEF; i++) begin
            o.out_index = i[IDX_W-1:0];
            if (ch == CH_FIRST) o.out_coeff = first_coeffs[i];
            else if (ch == CH_SECOND) o.out_coeff = second_coeffs[i];
            else o.out_coeff = (first_coeffs[i] > second_coeffs[i]) ?
                               first_coeffs[i] : second_coeffs[i];
            o.used_first = (ch != CH_SECOND);
            o.used_second = (ch != CH_FIRST);
            o.approximated = (ch == CH_FIRST) ? r.first_approx :
                             (ch == CH_SECOND) ? r.second_approx : 1'b1;
            o.out_last = (i == NCOEF - 1);
            pending_rsp.push_back(o);
         end
      endfunction

      task automatic check_result(input pds_rsp_type got);
         pds_rsp_type want;
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with no request waiting");
            return;
         end
         want = pending_rsp.pop_front();
         if (got.out_index !== want.out_index)
            report_mismatch($sformatf("out_index %0d, want %0d", got.out_index, want.out_index));
         if (got.out_coeff !== want.out_coeff)
            report_mismatch($sformatf("out_coeff %h, want %h", got.out_coeff, want.out_coeff));
         if (got.used_first !== want.used_first)
            report_mismatch($sformatf("used_first %b, want %b", got.used_first, want.used_first));
         if (got.used_second !== want.used_second)
            report_mismatch($sformatf("used_second %b, want %b",
                                      got.used_second, want.used_second));
         if (got.approximated !== want.approximated)
            report_mismatch($sformatf("approximated %b, want %b",
                                      got.approximated, want.approximated));
         if (got.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %b, want %b", got.out_last, want.out_last));
      endtask
   endclass

   selection_scoreboard board;
   int unsigned idle_pct;

   polynomial_dominance_select_unit #(.NUM_COEFFS(NCOEF), .SAMPLES(NSAMP)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) board.check_result(rsp_item);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** polynomial_dominance_select_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [COEFF_W-1:0] rand_coeff();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return COEFF_W'($urandom_range(0, 70000));
         3: return COEFF_W'($urandom_range(0, 4000));
         4: return COEFF_W'({$urandom(), $urandom()});
         default: return COEFF_W'($urandom_range(0, 1 << 17));
      endcase
   endfunction

   // One request: random idle gap, then hold start until the block takes it.
   task automatic send_request(input pds_req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(r);
   endtask

   // A full polynomial pair; mode picks dominating, equal, small-valued or random content.
   task automatic send_polynomial(input int mode);
      pds_req_type r;
      int order[NCOEF];
      for (int i = 0; i < NCOEF; i++) order[i] = i;
      order.shuffle();
      for (int i = 0; i < NCOEF; i++) begin
         r.select_max = 1'($urandom_range(0, 1));
         r.index = order[i][IDX_W-1:0];
         r.first_coeff = rand_coeff();
         r.second_coeff = rand_coeff();
         if (mode == 0) r.second_coeff = r.first_coeff - COEFF_W'(r.first_coeff != '0);
         else if (mode == 1) r.second_coeff = r.first_coeff;
         else if (mode == 2) begin
            r.first_coeff = COEFF_W'($urandom_range(0, 3000));
            r.second_coeff = COEFF_W'($urandom_range(0, 3000));
         end
         r.first_approx = 1'($urandom_range(0, 1));
         r.second_approx = 1'($urandom_range(0, 1));
         r.last = 1'b0;
         send_request(r);
      end
      // Extra pairs then a last that rewrites one already-loaded entry.
      repeat ($urandom_range(0, 2)) begin
         r.index = IDX_W'($urandom_range(0, NCOEF - 1));
         r.first_coeff = rand_coeff();
         r.second_coeff = rand_coeff();
         send_request(r);
      end
      r.last = 1'b1;
      r.select_max = 1'($urandom_range(0, 1));
      r.first_approx = 1'($urandom_range(0, 1));
      r.second_approx = 1'($urandom_range(0, 1));
      send_request(r);
   endtask

   initial begin
      pds_req_type r;
      board = new();
      error_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Directed: all-max versus all-zero in both modes, one equal entry, mixed.
      for (int i = 0; i < NCOEF; i++) begin
         r = '0;
         r.index = i[IDX_W-1:0];
         r.first_coeff = '1;
         r.first_approx = 1'b1;
         r.last = (i == NCOEF - 1);
         r.select_max = 1'b1;
         send_request(r);
      end
      r.select_max = 1'b0;
      send_request(r);
      r.second_coeff = r.first_coeff;
      r.second_approx = 1'b1;
      r.first_approx = 1'b0;
      send_request(r);
      r.index = IDX_W'(0);
      r.second_coeff = '0;
      r.first_coeff = 48'h1_0000;
      send_request(r);
      r.index = IDX_W'(1);
      r.first_coeff = '0;
      r.second_coeff = 48'hFFFF_FFFF_FFFF;
      r.select_max = 1'b1;
      send_request(r);
      // Random polynomials; the first few run without idle gaps.
      for (int n = 0; n < 8; n++) begin
         idle_pct = (n < 3) ? 0 : 9;
         send_polynomial($urandom_range(0, 4));
      end
      start <= 1'b0;
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("** polynomial_dominance_select_unit: PASSED **");
      end else begin
         $display("** polynomial_dominance_select_unit: FAILED **");
      end
      $finish;
   end

   final begin
   end
endmodule

FILE: filelist.f
design/pds_pkg.sv
design/pds_front.sv
design/pds_back.sv
design/polynomial_dominance_select_unit.sv
sim/tb_top.sv
